// ----- rtl/core/sfd_pkg.sv -----
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

   localparam int LEN_BITS = 12;

   localparam logic [7:0] CODE_END     = 8'hC0;
   localparam logic [7:0] CODE_ESC     = 8'hDB;
   localparam logic [7:0] CODE_ESC_END = 8'hDC;
   localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

   localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = LEN_BITS'(1560);

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_OVF   = 2'd2
   } kind_type;

   typedef struct packed {
      logic                escape;
      logic                drop;
      logic [LEN_BITS-1:0] count;
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [7:0]          data;
      logic [LEN_BITS-1:0] len;
   } result_type;

endpackage

// ----- rtl/core/sfd_decode.sv -----
// Combinational SLIP decode step: current state and one byte in, next state and result out.
module sfd_decode
   import sfd_pkg::*;
(
   input  logic [7:0]          rx_byte,
   input  state_type           cur,
   input  logic [LEN_BITS-1:0] max_len,
   output state_type           nxt,
   output logic                res_valid,
   output result_type          res
);

   logic [7:0] unesc;

   always_comb begin
      unesc = rx_byte;
      if (cur.escape) begin
         if (rx_byte == CODE_ESC_END) begin
            unesc = CODE_END;
         end else if (rx_byte == CODE_ESC_ESC) begin
            unesc = CODE_ESC;
         end
      end
   end

   always_comb begin
      nxt       = cur;
      res_valid = 1'b0;
      res.kind  = KIND_DATA;
      res.data  = 8'd0;
      res.len   = '0;
      if (rx_byte == CODE_END) begin
         // END leaves the escape flag alone
         nxt.drop = 1'b0;
         if (cur.count != '0) begin
            res_valid = 1'b1;
            res.kind  = KIND_FRAME;
            res.len   = cur.count;
            nxt.count = '0;
         end
      end else if (cur.drop) begin
         nxt = cur;
      end else if (rx_byte == CODE_ESC) begin
         nxt.escape = 1'b1;
      end else if (cur.count >= max_len) begin
         res_valid  = 1'b1;
         res.kind   = KIND_OVF;
         nxt.count  = '0;
         nxt.escape = 1'b0;
         nxt.drop   = 1'b1;
      end else begin
         res_valid  = 1'b1;
         res.kind   = KIND_DATA;
         res.data   = unesc;
         nxt.escape = 1'b0;
         nxt.count  = cur.count + LEN_BITS'(1);
      end
   end

endmodule

// ----- rtl/core/sfd_out_buf.sv -----
// Result register with a skid entry so the ready toward the decoder is registered.
module sfd_out_buf
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_res,
   output logic       in_ready,
   output logic       out_valid,
   output result_type out_res,
   input  logic       out_ready
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         // main slot frees up: refill from skid first, then from the input
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
            if (in_valid) begin
               skid_in       = in_res;
               skid_valid_in = 1'b1;
            end
         end else begin
            main_in       = in_res;
            main_valid_in = in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_in       = in_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while main slot empty");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_ff)))
      else $error("stalled result changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && main_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("skid entry lost under stall");

endmodule

// ----- rtl/core/slip_frame_decoder.sv -----
// Top level of the SLIP frame decoder: input register, decode state and result buffer.
//
// Usage:
//   req_*  : raw serial bytes, one per transaction, rx_byte in req_tdata[7:0].
//   rsp_*  : decoded results, at most one per input byte. rsp_tuser holds the
//            kind (data byte, frame complete, overflow); rsp_tdata holds the
//            decoded byte and the frame length.
//   csr_*  : write of max_frame_len; write it only while the decoder is idle.
// Path: an accepted byte lands in the input register, is decoded and is written
//   to the result register, or to the skid entry while that register is stalled.
// Throughput: one byte per cycle while the result buffer has room, set by the
//   combinational decode between the input register and the result register.
// Reset: synchronous; clears escape, drop mode, byte count and all valids, and
//   loads max_frame_len with 1560.
// Stall: when rsp_tready is low the result register holds, one more result goes
//   into the skid entry, and req_tready drops once that entry and the input
//   register are both full. No transaction is lost or repeated.
module slip_frame_decoder
   import sfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // req_tdata: [7:0] rx_byte
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   // rsp_tdata: [7:0] data_byte, [19:8] frame_length, [23:20] zero
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [1:0]          rsp_tuser,
   // csr_data: [11:0] max_frame_len
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_BITS-1:0] csr_data
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // decode state and config
   state_type           state_ff, state_in;
   logic [LEN_BITS-1:0] max_len_ff, max_len_in;

   state_type  nxt_state;
   logic       dec_valid;
   result_type dec_res;
   logic       buf_ready;
   logic       advance;
   result_type out_res;

   assign csr_ready = 1'b1;

   // the buffer's ready is registered, so no path runs from rsp_tready here
   assign advance    = in_valid_ff && buf_ready;
   assign req_tready = !in_valid_ff || buf_ready;

   sfd_decode u_decode (
      .rx_byte   (in_byte_ff),
      .cur       (state_ff),
      .max_len   (max_len_ff),
      .nxt       (nxt_state),
      .res_valid (dec_valid),
      .res       (dec_res)
   );

   sfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (advance && dec_valid),
      .in_res    (dec_res),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {4'd0, out_res.len, out_res.data};
   assign rsp_tuser = out_res.kind;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      state_in    = state_ff;
      max_len_in  = max_len_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = nxt_state;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end
      if (csr_valid && csr_ready) begin
         max_len_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         max_len_ff  <= MAX_LEN_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         max_len_ff  <= max_len_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // in drop mode nothing is counted
   a_drop_zero_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.drop |-> (state_ff.count == '0))
      else $error("byte count nonzero in drop mode");

   // an overflow result always puts the decoder into drop mode
   a_ovf_enters_drop: assert property (@(posedge clock) disable iff (reset)
      (advance && dec_valid && dec_res.kind == KIND_OVF) |=> state_ff.drop)
      else $error("overflow without drop mode");

   // a frame-complete result never reports an empty frame
   a_frame_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_FRAME) |-> (rsp_tdata[19:8] != '0))
      else $error("empty frame reported");

   // state moves only when a byte is consumed
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("decode state changed without a byte");

endmodule

// ----- test/slip_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the SLIP frame decoder: watches all channels, predicts and compares results.
module slip_frame_checker
   import sfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [23:0]         rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [LEN_BITS-1:0] csr_data,
   output int                  error_count,
   output int                  pending_results
);

   // predicted decoder state
   logic                esc_armed;
   logic                dropping;
   logic [LEN_BITS-1:0] frame_count;
   logic [LEN_BITS-1:0] len_limit;

   result_type          expected_results[$];
   int                  mismatches;

   function automatic void decode_rx_byte(input logic [7:0] rx);
      logic [7:0] b;
      result_type r;
      b = rx;
      r = '0;
      if (rx == CODE_END) begin
         dropping = 1'b0;
         if (frame_count != '0) begin
            r.kind = KIND_FRAME;
            r.len  = frame_count;
            frame_count = '0;
            expected_results.push_back(r);
         end
      end else if (!dropping) begin
         if (rx == CODE_ESC) begin
            esc_armed = 1'b1;
         end else begin
            if (esc_armed) begin
               esc_armed = 1'b0;
               if (rx == CODE_ESC_END) b = CODE_END;
               else if (rx == CODE_ESC_ESC) b = CODE_ESC;
            end
            if (frame_count >= len_limit) begin
               frame_count = '0;
               esc_armed   = 1'b0;
               dropping    = 1'b1;
               r.kind      = KIND_OVF;
            end else begin
               frame_count = frame_count + 1'b1;
               r.kind      = KIND_DATA;
               r.data      = b;
            end
            expected_results.push_back(r);
         end
      end
   endfunction

   function automatic int field_diff(input string label, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         esc_armed   = 1'b0;
         dropping    = 1'b0;
         frame_count = '0;
         len_limit   = MAX_LEN_RESET;
         expected_results.delete();
      end else begin
         // results leave before the new byte is decoded; latency keeps them apart
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d data %0d len %0d",
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[19:8]);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               mismatches += field_diff("kind", 16'(want.kind), 16'(rsp_tuser));
               mismatches += field_diff("data_byte", 16'(want.data), 16'(rsp_tdata[7:0]));
               mismatches += field_diff("frame_length", 16'(want.len), 16'(rsp_tdata[19:8]));
               mismatches += field_diff("tdata pad", 16'd0, 16'(rsp_tdata[23:20]));
            end
         end
         if (csr_valid && csr_ready) len_limit = csr_data;
         if (req_tvalid && req_tready) decode_rx_byte(req_tdata);
      end
      pending_results <= expected_results.size();
      error_count     <= mismatches;
   end

endmodule

// ----- test/tb_slip_frame_decoder.sv -----
`timescale 1ns / 1ps
// Testbench top for the SLIP frame decoder: stimulus, stall patterns and final verdict.
module tb_slip_frame_decoder;
   import sfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES   = 4;     // covers bytes that give no result
   localparam int FINAL_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 400;

   // receiver stall patterns
   localparam int READY_ALWAYS   = 0;
   localparam int READY_COIN     = 1;
   localparam int READY_SPARSE   = 2;
   localparam int READY_PERIODIC = 3;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [23:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_BITS-1:0] csr_data;

   int                  error_count;
   int                  pending_results;
   int                  burst_left;
   int                  idle_cycles;
   int                  sent_items;
   int                  ready_mode;
   logic [7:0]          ready_tick;
   logic [LEN_BITS-1:0] cur_limit;

   slip_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   slip_frame_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: picks a new stall pattern each time ready_tick[5:0] wraps to zero. The
   // always-ready pattern gives long stretches with no backpressure at all.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1'b1;
      if (ready_tick[5:0] == 6'd0) ready_mode <= $urandom_range(READY_ALWAYS, READY_PERIODIC);
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         default:        rsp_tready <= (ready_tick[2:0] != 3'd7) && (ready_tick[2:0] != 3'd3);
      endcase
   end

   // Watchdog: a hang shows up as a long run of cycles with no transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One input transaction. The sender runs in bursts; between bursts it
   // drops tvalid for a random gap, or for none at all so bursts can merge.
   task automatic send_rx_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   // Hold the sender until every expected result is out, then DRAIN_CYCLES more,
   // since a trailing ESC or dropped byte gives no result.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // max_frame_len is only written with the decoder idle.
   task automatic write_max_len(input logic [LEN_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_limit = value;
   endtask

   // A frame body of body_len units. Clean frames carry random payload with
   // escape pairs mixed in; noisy ones are raw random bytes and may lose END.
   task automatic send_frame(input int body_len, input bit noisy);
      int pick;
      for (int i = 0; i < body_len; i++) begin
         pick = $urandom_range(0, 99);
         if (noisy) begin
            if (pick < 10) send_rx_byte(CODE_ESC);
            else if (pick < 15) send_rx_byte(CODE_END);
            else send_rx_byte(8'($urandom_range(0, 255)));
         end else if (pick < 18) begin
            send_rx_byte(CODE_ESC);
            case ($urandom_range(0, 7))
               0, 1, 2: send_rx_byte(CODE_ESC_END);
               3, 4, 5: send_rx_byte(CODE_ESC_ESC);
               6:       send_rx_byte(CODE_END);  // END while escaped
               default: send_rx_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            send_rx_byte(8'($urandom_range(0, 255)));
         end
      end
      if (!noisy || ($urandom_range(0, 1) == 1)) send_rx_byte(CODE_END);
   endtask

   initial begin
      int target;
      int frames_left;
      int body_len;
      bit held;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      burst_left  = 0;
      idle_cycles = 0;
      sent_items  = 0;
      ready_mode  = READY_ALWAYS;
      ready_tick  = '0;
      cur_limit   = MAX_LEN_RESET;
      held        = 1'b0;
      frames_left = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset limit, data extremes and every escape form ---
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
      send_rx_byte(CODE_ESC);
      send_rx_byte(CODE_ESC_END);   // decodes to END value
      send_rx_byte(CODE_ESC);
      send_rx_byte(CODE_ESC_ESC);   // decodes to ESC value
      send_rx_byte(CODE_ESC);
      send_rx_byte(8'h41);          // passes through unchanged
      send_rx_byte(CODE_END);       // frame done, length 5
      send_rx_byte(CODE_END);       // empty frame, no result
      send_rx_byte(CODE_ESC);
      send_rx_byte(CODE_END);       // escape survives the boundary
      send_rx_byte(CODE_ESC_END);   // still unescaped
      send_rx_byte(CODE_END);

      // smallest nonzero limit: overflow, drop mode, escape cleared by overflow
      write_max_len(12'd1);
      send_rx_byte(8'h11);
      send_rx_byte(CODE_ESC);
      send_rx_byte(CODE_ESC_END);   // overflows
      send_rx_byte(8'h33);          // dropped
      send_rx_byte(CODE_ESC);       // dropped, no escape armed
      send_rx_byte(CODE_END);       // leaves drop mode, no result
      send_rx_byte(8'h44);
      send_rx_byte(CODE_END);

      // zero limit: the first data byte of a frame already overflows
      write_max_len(12'd0);
      send_rx_byte(8'h55);
      send_rx_byte(CODE_END);

      // largest limit
      write_max_len(12'd4095);
      send_rx_byte(8'hAA);
      send_rx_byte(CODE_END);

      // --- random: phases of random limits, mostly small ones ---
      target = sent_items + RANDOM_ITEMS;
      while (sent_items < target) begin
         if (frames_left == 0) begin
            case ($urandom_range(0, 5))
               0:       write_max_len(12'd1);
               1, 2:    write_max_len(12'($urandom_range(2, 16)));
               3, 4:    write_max_len(12'($urandom_range(17, 64)));
               default: write_max_len(12'($urandom_range(65, 4095)));
            endcase
            frames_left = $urandom_range(3, 10);
         end
         frames_left--;
         if (cur_limit <= 40) body_len = $urandom_range(0, cur_limit + 3);
         else body_len = $urandom_range(0, 30);
         send_frame(body_len, $urandom_range(0, 9) == 0);
         // one hold-off mid phase, apart from the ones around CSR writes
         if (!held && (sent_items > target - RANDOM_ITEMS / 2)) begin
            held = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (FINAL_CYCLES) @(posedge clock);
      if ((error_count == 0) && (pending_results == 0)) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
